### src/grt_pkg.sv
// Shared types, constants and codes of the grid ray traversal block.
package grt_pkg;

	localparam int MAP_DIM_DEF = 64;
	localparam int MAX_REACH = 31;
	localparam int ANGLE_BITS = 12;
	localparam int PHASE_BITS = 16;
	localparam int RESULT_LIMIT = 63;
	localparam int DIV_W = 33;
	localparam int QUOT_W = 17;
	localparam int CNT_W = 5;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST = 1'b1;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_RX = 2'd2;
	localparam logic [1:0] OP_RY = 2'd3;

	typedef struct packed {
		logic        action;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic        cell_blocked;
		logic        cell_transparent;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [11:0] view_angle;
		logic [11:0] ray_offset;
		logic [4:0]  max_distance;
		logic        stop_on_wall;
	} req_t;

	typedef struct packed {
		logic [5:0] visit_x;
		logic [5:0] visit_y;
		logic       right_side;
		logic       top_side;
		logic       in_map;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       clear_step;
		logic       write_cell;
		logic       load_cast;
		logic [1:0] sel;
		logic       mul;
		logic       div_start;
		logic       div_store;
		logic       side_init;
		logic       issue;
		logic       marker;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic div_done;
		logic cur_ok;
		logic halt;
		logic count_full;
		logic count_zero;
	} status_t;

endpackage

### src/grt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module grt_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/grt_div.sv
// Restoring divider that develops one quotient bit per cycle.
module grt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [grt_pkg::DIV_W-1:0]       rem_init,
	input  logic [grt_pkg::DIV_W-1:0]       den,
	input  logic [grt_pkg::CNT_W-1:0]       nbits,
	output logic                            done,
	output logic [grt_pkg::QUOT_W-1:0]      quot
);

	logic [grt_pkg::DIV_W-1:0]  rem_q;
	logic [grt_pkg::DIV_W-1:0]  den_q;
	logic [grt_pkg::QUOT_W-1:0] quot_q;
	logic [grt_pkg::CNT_W-1:0]  cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [grt_pkg::DIV_W:0]    trial;
	logic [grt_pkg::DIV_W:0]    diff;
	logic                       ge;

	// The trial value is the remainder doubled, which always fits one extra bit.
	assign trial = {rem_q, 1'b0};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == grt_pkg::CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[grt_pkg::DIV_W-1:0] : trial[grt_pkg::DIV_W-1:0];
			quot_q <= {quot_q[grt_pkg::QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### src/grt_dp.sv
// Datapath: map store, configuration, sine and reciprocal setup, cell walker, result register.
module grt_dp #(
	parameter int MAP_DIM = grt_pkg::MAP_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  grt_pkg::req_t    req,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data,
	input  grt_pkg::cmd_t    cmd,
	output grt_pkg::status_t status,
	output logic             result_valid,
	output grt_pkg::result_t result
);

	localparam int MB = $clog2(MAP_DIM);
	localparam int AW = 2 * MB;
	localparam int DEPTH = 1 << AW;
	localparam int PHASE_SHIFT = grt_pkg::PHASE_BITS - grt_pkg::ANGLE_BITS;

	logic [6:0]  map_width_q, map_height_q;
	logic [6:0]  w_eff_q, h_eff_q;
	logic [15:0] pos_x_q, pos_y_q;
	logic [15:0] phase_q;
	logic [4:0]  reach_q;
	logic        stop_q;
	logic [28:0] q_q;
	logic [14:0] sin_mag_q, cos_mag_q;
	logic        sin_neg_q, cos_neg_q;
	logic [15:0] rx_q, ry_q;
	logic signed [7:0] col_q, row_q;
	logic signed [7:0] start_col, start_row;
	logic [23:0] sdx_q, sdy_q;
	logic [5:0]  count_q;
	logic        s1_valid_q;
	logic signed [7:0] s1_col_s1, s1_row_s1;
	logic [5:0]  s1_idx_s1;
	logic        result_valid_q;
	grt_pkg::result_t result_q;
	logic [AW-1:0] clr_addr_q;

	logic [11:0] angle;
	logic [15:0] phase_c;
	logic [14:0] h;
	logic        trig;
	logic [grt_pkg::DIV_W-1:0] rem_init, den;
	logic [grt_pkg::CNT_W-1:0] nbits;
	logic        div_done;
	logic [grt_pkg::QUOT_W-1:0] quot;
	logic [15:0] recip_val;
	logic [14:0] recip_mag;
	logic [10:0] part_x, part_y;
	logic [26:0] prod_x, prod_y;
	logic signed [7:0] dcol, drow;
	logic        cur_ok;
	logic        step_x;
	logic [24:0] sum_x, sum_y;
	logic [1:0]  flags;
	logic        last_now;
	logic [8:0]  cx_ext, cy_ext;
	logic        cell_ok;
	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr, cell_addr;
	logic [1:0]  mem_wdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= 7'd64;
			map_height_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grt_pkg::REG_WIDTH:  map_width_q <= cfg_data;
				grt_pkg::REG_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Map store and its clearing pass.
	assign cx_ext = 9'(req.cell_x);
	assign cy_ext = 9'(req.cell_y);
	assign cell_ok = (cx_ext < 9'(MAP_DIM)) && (cy_ext < 9'(MAP_DIM));
	assign cell_addr = {cy_ext[MB-1:0], cx_ext[MB-1:0]};
	assign mem_we = cmd.clear_step || (cmd.write_cell && cell_ok);
	assign mem_waddr = cmd.clear_step ? clr_addr_q : cell_addr;
	assign mem_wdata = cmd.clear_step ? 2'b00 : {req.cell_transparent, req.cell_blocked};
	assign mem_raddr = {row_q[MB-1:0], col_q[MB-1:0]};

	grt_ram #(
		.WIDTH(2),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Ray parameters captured when a cast is accepted.
	assign angle = req.view_angle + req.ray_offset;

	always_ff @(posedge clk) begin
		if (cmd.load_cast) begin
			pos_x_q <= req.pos_x;
			pos_y_q <= req.pos_y;
			phase_q <= 16'(angle) << PHASE_SHIFT;
			reach_q <= (req.max_distance > 5'(grt_pkg::MAX_REACH)) ?
				5'(grt_pkg::MAX_REACH) : req.max_distance;
			stop_q <= req.stop_on_wall;
			w_eff_q <= (9'(map_width_q) > 9'(MAP_DIM)) ? 7'(MAP_DIM) : map_width_q;
			h_eff_q <= (9'(map_height_q) > 9'(MAP_DIM)) ? 7'(MAP_DIM) : map_height_q;
		end
	end

	// Sine magnitudes by the rational approximation, then Q8.8 reciprocals.
	assign phase_c = phase_q + 16'd16384;
	assign h = (cmd.sel == grt_pkg::OP_COS) ? phase_c[14:0] : phase_q[14:0];
	assign trig = (cmd.sel == grt_pkg::OP_SIN) || (cmd.sel == grt_pkg::OP_COS);
	assign recip_mag = (cmd.sel == grt_pkg::OP_RX) ? sin_mag_q : cos_mag_q;
	assign rem_init = trig ? (33'(q_q) << 3) : 33'd32;
	assign den = trig ? (33'h1_4000_0000 - (33'(q_q) << 2)) : 33'(recip_mag);
	assign nbits = trig ? 5'd15 : 5'd17;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			q_q <= 29'(h) * 29'(16'd32768 - 16'(h));
		end
	end

	grt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.rem_init(rem_init),
		.den     (den),
		.nbits   (nbits),
		.done    (div_done),
		.quot    (quot)
	);

	// Magnitudes below 64 give a reciprocal of at least 2^16, which saturates.
	assign recip_val = ((recip_mag < 15'd64) || quot[16]) ? 16'hFFFF : quot[15:0];

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.sel)
				grt_pkg::OP_SIN: begin
					sin_mag_q <= quot[14:0];
					sin_neg_q <= phase_q[15] && (quot[14:0] != 15'd0);
				end
				grt_pkg::OP_COS: begin
					cos_mag_q <= quot[14:0];
					cos_neg_q <= phase_c[15] && (quot[14:0] != 15'd0);
				end
				grt_pkg::OP_RX: rx_q <= recip_val;
				default: ry_q <= recip_val;
			endcase
		end
	end

	// Walker.
	assign start_col = $signed({2'b00, pos_x_q[15:10]});
	assign start_row = $signed({2'b00, pos_y_q[15:10]});
	assign part_x = sin_neg_q ? {1'b0, pos_x_q[9:0]} : 11'd1024 - {1'b0, pos_x_q[9:0]};
	assign part_y = cos_neg_q ? {1'b0, pos_y_q[9:0]} : 11'd1024 - {1'b0, pos_y_q[9:0]};
	assign prod_x = 27'(part_x) * 27'(rx_q);
	assign prod_y = 27'(part_y) * 27'(ry_q);

	assign dcol = (col_q > start_col) ? col_q - start_col : start_col - col_q;
	assign drow = (row_q > start_row) ? row_q - start_row : start_row - row_q;
	assign cur_ok = (col_q >= 8'sd0) && (row_q >= 8'sd0)
		&& (col_q < $signed({1'b0, w_eff_q})) && (row_q < $signed({1'b0, h_eff_q}))
		&& (dcol <= $signed({3'b000, reach_q})) && (drow <= $signed({3'b000, reach_q}));
	assign step_x = sdx_q < sdy_q;
	assign sum_x = 25'(sdx_q) + 25'(rx_q);
	assign sum_y = 25'(sdy_q) + 25'(ry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sdx_q <= '0;
			sdy_q <= '0;
			count_q <= '0;
		end else if (cmd.side_init) begin
			col_q <= start_col;
			row_q <= start_row;
			sdx_q <= 24'(prod_x[26:10]);
			sdy_q <= 24'(prod_y[26:10]);
			count_q <= '0;
		end else if (cmd.issue) begin
			count_q <= count_q + 1'b1;
			if (step_x) begin
				col_q <= sin_neg_q ? col_q - 8'sd1 : col_q + 8'sd1;
				sdx_q <= sum_x[24] ? 24'hFFFFFF : sum_x[23:0];
			end else begin
				row_q <= cos_neg_q ? row_q - 8'sd1 : row_q + 8'sd1;
				sdy_q <= sum_y[24] ? 24'hFFFFFF : sum_y[23:0];
			end
		end
	end

	// The map flags of an issued cell arrive in the following cycle, together with the next cell's range check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			s1_col_s1 <= col_q;
			s1_row_s1 <= row_q;
			s1_idx_s1 <= count_q;
		end
	end

	assign last_now = (stop_q && flags[0] && !flags[1]) || !cur_ok
		|| (s1_idx_s1 == 6'(grt_pkg::RESULT_LIMIT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= s1_valid_q || cmd.marker;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.marker) begin
			result_q <= '{visit_x: 6'd0, visit_y: 6'd0, right_side: 1'b0,
				top_side: 1'b0, in_map: 1'b0, last: 1'b1};
		end else if (s1_valid_q) begin
			result_q <= '{visit_x: s1_col_s1[5:0], visit_y: s1_row_s1[5:0],
				right_side: s1_col_s1 > start_col, top_side: s1_row_s1 > start_row,
				in_map: 1'b1, last: last_now};
		end
	end

	assign status.clear_done = cmd.clear_step && (clr_addr_q == {AW{1'b1}});
	assign status.div_done = div_done;
	assign status.cur_ok = cur_ok;
	assign status.halt = s1_valid_q && last_now;
	assign status.count_full = count_q == 6'(grt_pkg::RESULT_LIMIT);
	assign status.count_zero = count_q == 6'd0;

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.in_map |-> result_q.last)
		else $error("marker result without last");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> cur_ok && !status.count_full)
		else $error("cell issued outside the map or past the result limit");

	a_last_ends_ray: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.last |-> !s1_valid_q)
		else $error("cell pending after the final result");

endmodule

### src/grt_ctrl.sv
// Controller state machine: clearing pass, item accept, setup sequence and walk.
module grt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             action,
	input  grt_pkg::status_t status,
	output grt_pkg::cmd_t    cmd,
	output logic             busy
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DWAIT = 3'd4;
	localparam logic [2:0] S_SIDE = 3'd5;
	localparam logic [2:0] S_WALK = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.sel = sel_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (action == grt_pkg::ACT_CAST) begin
						cmd.load_cast = 1'b1;
						sel_d = grt_pkg::OP_SIN;
						state_d = S_MUL;
					end else begin
						cmd.write_cell = 1'b1;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (status.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == grt_pkg::OP_RY) begin
						state_d = S_SIDE;
					end else begin
						sel_d = sel_q + 2'd1;
						state_d = S_MUL;
					end
				end
			end
			S_SIDE: begin
				cmd.side_init = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				// A start cell outside the map yields the single marker result.
				if (status.count_zero && !status.cur_ok) begin
					cmd.marker = 1'b1;
					state_d = S_IDLE;
				end else if (status.halt) begin
					state_d = S_IDLE;
				end else begin
					cmd.issue = status.cur_ok && !status.count_full;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sel_q <= grt_pkg::OP_SIN;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

### src/grid_ray_traversal.sv
// Top level of the grid ray traversal block: controller and datapath.
// After reset the map's 2^(2*ceil(log2(MAP_DIM))) entries (4096 at the default size) are cleared
// one entry per cycle; busy stays high until that pass ends. A map write leaves busy low.
// A cast computes two sines and two reciprocals in the shared one-bit-per-cycle divider, then
// the start side distances, and then issues one cell per cycle until the ray ends.
module grid_ray_traversal #(
	parameter int MAP_DIM = grt_pkg::MAP_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  grt_pkg::req_t    req,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data,
	output logic             result_valid,
	output grt_pkg::result_t result
);

	grt_pkg::cmd_t    cmd;
	grt_pkg::status_t status;

	grt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(req.action),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	grt_dp #(
		.MAP_DIM(MAP_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

### sim/grt_checker.sv
// Checker for the grid ray traversal block: it predicts the visited cells and compares them.
module grt_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  grt_pkg::req_t    req,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data,
	input  logic             result_valid,
	input  grt_pkg::result_t result,
	output int               fail_count,
	output int               visits_checked,
	output int               visits_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = 64;
	localparam longint DIST_SAT = 64'hFFFFFF;
	localparam longint RECIP_SAT = 65535;

	logic [1:0] cell_map [0:DIM*DIM-1];
	int cols_in_use;
	int rows_in_use;
	grt_pkg::result_t visit_q [$];

	assign visits_pending = visit_q.size();

	// Bhaskara sine of a 16-bit phase, signed Q1.14.
	function automatic longint bhaskara_sine(logic [15:0] ph);
		longint h;
		longint q;
		longint den;
		longint mag;
		h = ph & 16'h7FFF;
		q = h * (32768 - h);
		den = (longint'(5) << 30) - 4 * q;
		mag = (q << 18) / den;
		return ph[15] ? -mag : mag;
	endfunction

	function automatic longint recip_q88(longint s);
		longint mag;
		longint r;
		mag = (s < 0) ? -s : s;
		if (mag == 0)
			return RECIP_SAT;
		r = (longint'(1) << 22) / mag;
		return (r > RECIP_SAT) ? RECIP_SAT : r;
	endfunction

	function automatic longint sat_dist(longint a, longint b);
		return (a + b > DIST_SAT) ? DIST_SAT : a + b;
	endfunction

	function automatic int distance(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	task automatic trace_ray(grt_pkg::req_t r);
		logic [11:0] heading;
		logic [15:0] ph;
		longint sn, cs, rx, ry, dx, dy;
		int col0, row0, col, row, reach, count, wd, ht;
		logic [1:0] flags;
		grt_pkg::result_t v;
		heading = r.view_angle + r.ray_offset;
		ph = {heading, 4'b0};
		sn = bhaskara_sine(ph);
		cs = bhaskara_sine(ph + 16'h4000);
		rx = recip_q88(sn);
		ry = recip_q88(cs);
		col0 = int'(r.pos_x[15:10]);
		row0 = int'(r.pos_y[15:10]);
		dx = ((sn >= 0 ? 1024 - r.pos_x[9:0] : r.pos_x[9:0]) * rx) >> 10;
		dy = ((cs >= 0 ? 1024 - r.pos_y[9:0] : r.pos_y[9:0]) * ry) >> 10;
		reach = (r.max_distance > grt_pkg::MAX_REACH) ? grt_pkg::MAX_REACH
			: int'(r.max_distance);
		wd = (cols_in_use < DIM) ? cols_in_use : DIM;
		ht = (rows_in_use < DIM) ? rows_in_use : DIM;
		col = col0;
		row = row0;
		count = 0;
		while (count < grt_pkg::RESULT_LIMIT) begin
			if (col < 0 || row < 0 || col >= wd || row >= ht ||
				distance(col, col0) > reach || distance(row, row0) > reach)
				break;
			v = '0;
			v.visit_x = col[5:0];
			v.visit_y = row[5:0];
			v.right_side = col > col0;
			v.top_side = row > row0;
			v.in_map = 1'b1;
			visit_q.push_back(v);
			count++;
			flags = cell_map[row*DIM + col];
			if (r.stop_on_wall && flags[0] && !flags[1])
				break;
			if (dx < dy) begin
				col += (sn >= 0) ? 1 : -1;
				dx = sat_dist(dx, rx);
			end else begin
				row += (cs >= 0) ? 1 : -1;
				dy = sat_dist(dy, ry);
			end
		end
		// A ray that starts off the map still yields one marker entry.
		if (count == 0) begin
			v = '0;
			visit_q.push_back(v);
		end
		visit_q[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		grt_pkg::result_t want;
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++)
				cell_map[i] = 2'b00;
			cols_in_use = 64;
			rows_in_use = 64;
			visit_q.delete();
			fail_count = 0;
			visits_checked = 0;
		end else begin
			if (result_valid) begin
				if (visit_q.size() == 0) begin
					$display("%0t: unexpected visit, expected none, actual %p", $time, result);
					fail_count++;
				end else begin
					want = visit_q.pop_front();
					visits_checked++;
					if (result.visit_x !== want.visit_x || result.visit_y !== want.visit_y ||
						result.right_side !== want.right_side ||
						result.top_side !== want.top_side ||
						result.in_map !== want.in_map || result.last !== want.last) begin
						$display("%0t: visit mismatch, expected %p, actual %p",
							$time, want, result);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == grt_pkg::REG_WIDTH)
					cols_in_use = int'(cfg_data);
				else
					rows_in_use = int'(cfg_data);
			end
			if (start && !busy) begin
				if (req.action == grt_pkg::ACT_WRITE)
					cell_map[req.cell_y*DIM + req.cell_x] = {req.cell_transparent, req.cell_blocked};
				else
					trace_ray(req);
			end
		end
	end
endmodule

### sim/tb_top.sv
// Testbench top for the grid ray traversal block: stimulus, configuration phases and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	grt_pkg::req_t req = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = grt_pkg::REG_WIDTH;
	logic [6:0] cfg_data = '0;
	logic result_valid;
	grt_pkg::result_t result;
	int fail_count, visits_checked, visits_pending;
	int cycles = 0;
	int casts = 0;
	int writes = 0;
	int cols = 64;
	bit idle_on = 1'b1;

	grid_ray_traversal dut (.*);

	grt_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL grid_ray_traversal");
			$finish;
		end
	end

	// Start stays high from one request to the next but for idle gaps and size changes.
	task automatic send(grt_pkg::req_t r);
		if (idle_on && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (r.action == grt_pkg::ACT_CAST) casts++;
		else writes++;
	endtask

	task automatic put_cell(int x, int y, bit blk, bit trn);
		grt_pkg::req_t r;
		r = '0;
		r.action = grt_pkg::ACT_WRITE;
		r.cell_x = 6'(x);
		r.cell_y = 6'(y);
		r.cell_blocked = blk;
		r.cell_transparent = trn;
		send(r);
	endtask

	task automatic cast(int px, int py, int ang, int off, int reach, bit stop);
		grt_pkg::req_t r;
		r = grt_pkg::req_t'($urandom());
		r.action = grt_pkg::ACT_CAST;
		r.pos_x = 16'(px);
		r.pos_y = 16'(py);
		r.view_angle = 12'(ang);
		r.ray_offset = 12'(off);
		r.max_distance = 5'(reach);
		r.stop_on_wall = stop;
		send(r);
	endtask

	task automatic set_size(int w, int h);
		start <= 1'b0;
		@(posedge clk);
		while (visits_pending != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= grt_pkg::REG_WIDTH;
		cfg_data <= 7'(w);
		@(posedge clk);
		cfg_index <= grt_pkg::REG_HEIGHT;
		cfg_data <= 7'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		cols = (w == 0) ? 1 : ((w > 64) ? 64 : w);
	endtask

	task automatic random_request();
		grt_pkg::req_t r;
		r = grt_pkg::req_t'({$urandom(), $urandom(), $urandom()});
		if ($urandom_range(99) < 30) begin
			r.action = grt_pkg::ACT_WRITE;
		end else begin
			r.action = grt_pkg::ACT_CAST;
			// Most rays start inside the columns in use so that they walk.
			if ($urandom_range(99) < 85)
				r.pos_x = 16'($urandom_range(cols * 1024 - 1));
		end
		send(r);
	endtask

	initial begin
		int widths [5] = '{64, 1, 17, 127, 0};
		int heights [5] = '{64, 1, 40, 64, 127};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: walls, plain and transparent, then the edge cases.
		put_cell(34, 32, 1, 0);
		put_cell(32, 35, 1, 1);
		put_cell(30, 32, 1, 0);
		put_cell(63, 63, 1, 0);
		put_cell(0, 0, 1, 1);
		cast(32*1024 + 512, 32*1024 + 512, 1024, 0, 31, 1);
		cast(32*1024 + 512, 32*1024 + 512, 0, 0, 31, 1);
		cast(32*1024 + 512, 32*1024 + 512, 2048, 0, 31, 0);
		cast(32*1024 + 512, 32*1024 + 512, 3072, 0, 31, 1);
		cast(32*1024 + 512, 32*1024 + 512, 4095, 1025, 31, 1);
		cast(32*1024 + 512, 32*1024 + 512, 512, 0, 31, 0);
		cast(0, 0, 512, 0, 31, 0);
		cast(65535, 65535, 2560, 0, 31, 1);
		cast(65535, 65535, 4095, 4095, 0, 1);
		cast(10*1024, 20*1024 + 1023, 300, 77, 5, 0);
		cast(1023, 1023, 2048, 2048, 31, 0);
		cast(5*1024, 5*1024, 1536, 0, 31, 0);

		for (int p = 0; p < 5; p++) begin
			if (p > 0) set_size(widths[p], heights[p]);
			if (p == 1) cast(65535, 0, 0, 0, 31, 0);
			for (int i = 0; i < 80; i++) begin
				idle_on = !(p == 2);
				random_request();
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (visits_pending != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d ray casts and %0d map writes over five map sizes,", casts, writes);
		$display("with %0d visited cells compared.", visits_checked);
		if (fail_count == 0)
			$display("PASS grid_ray_traversal");
		else
			$display("FAIL grid_ray_traversal");
		$finish;
	end
endmodule

### files.f
src/grt_pkg.sv
src/grt_ram.sv
src/grt_div.sv
src/grt_dp.sv
src/grt_ctrl.sv
src/grid_ray_traversal.sv
sim/grt_checker.sv
sim/tb_top.sv
